// ===== hw/rtl/tmrs_pkg.sv =====
// package for the thread-masked register scoreboard
// types, kind codes, state codes and sizes for the scoreboard modules
// no dependencies
`timescale 1ns / 1ps

package tmrs_pkg;

  localparam int WARPS     = 32;
  localparam int REGS      = 64;
  localparam int WARP_SIZE = 32;
  localparam int SLOTS     = 6;

  localparam int WARP_W  = 5;
  localparam int REG_W   = 6;
  localparam int ADDR_W  = WARP_W + REG_W;
  localparam int DEPTH   = 2 ** ADDR_W;
  localparam int ENTRY_W = 2 * WARP_SIZE;
  localparam int CNT_W   = 6;
  localparam int SLOT_W  = $clog2(SLOTS);

  typedef enum logic [1:0] {
    KIND_RESERVE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CHECK   = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [WARP_SIZE-1:0] busy_new;
    logic [WARP_SIZE-1:0] long_new;
    logic                 dbl;
    logic                 hit;
    logic                 inc;
    logic                 dec;
  } lane_res_t;

  typedef struct packed {
    logic             dbl;
    logic             hit;
    logic [CNT_W-1:0] count_new;
  } merge_res_t;

endpackage

// ===== hw/rtl/tmrs_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module tmrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tmrs_lane.sv =====
// one scoreboard lane: new busy and long-op masks for one register slot
// depends on tmrs_pkg
`timescale 1ns / 1ps

module tmrs_lane
  import tmrs_pkg::*;
(
  input  kind_t                kind,
  input  logic [WARP_SIZE-1:0] mask,
  input  logic                 long_load,
  input  logic                 active,
  input  logic                 first,
  input  logic [ENTRY_W-1:0]   rdata,
  output lane_res_t            res
);

  logic [WARP_SIZE-1:0] old_busy;
  logic [WARP_SIZE-1:0] old_long;

  assign old_busy = rdata[WARP_SIZE-1:0];
  assign old_long = rdata[ENTRY_W-1:WARP_SIZE];

  always_comb begin
    res          = '0;
    res.busy_new = old_busy;
    res.long_new = old_long;
    unique case (kind)
      KIND_RESERVE: begin
        res.busy_new = old_busy | mask;
        res.long_new = long_load ? (old_long | mask) : old_long;
        // a repeated register already carries this item's mask
        res.dbl      = active && (first ? ((old_busy & mask) != '0) : (mask != '0));
        res.inc      = active && first && (old_busy == '0) && (mask != '0);
      end
      KIND_RELEASE: begin
        res.busy_new = old_busy & ~mask;
        res.long_new = old_long & ~mask;
        res.dec      = active && first && (old_busy != '0) && ((old_busy & ~mask) == '0);
      end
      KIND_CHECK: begin
        res.hit = active && ((old_busy & mask) != '0);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/tmrs_merge.sv =====
// merging stage: combines lane flags and busy count changes
// depends on tmrs_pkg
`timescale 1ns / 1ps

module tmrs_merge
  import tmrs_pkg::*;
(
  input  lane_res_t        res [SLOTS],
  input  logic [CNT_W-1:0] count_old,
  output merge_res_t       merged
);

  always_comb begin
    merged           = '0;
    merged.count_new = count_old;
    for (int i = 0; i < SLOTS; i++) begin
      merged.dbl       = merged.dbl | res[i].dbl;
      merged.hit       = merged.hit | res[i].hit;
      merged.count_new = merged.count_new + CNT_W'(res[i].inc) - CNT_W'(res[i].dec);
    end
  end

endmodule

// ===== hw/rtl/thread_masked_register_scoreboard.sv =====
// write-pending scoreboard with per-thread masks, one lane and ram copy per slot
// result strobe (valid) is raised after the EVAL state and the last slot write-back in WRITE
// a new item is taken only after the last one's six slot write-backs through each ram's write port
// after rst a clearing pass over all DEPTH ram entries runs with busy high
// the result strobe (valid) is shown for one cycle only; the receiver cannot stall
// depends on tmrs_pkg, tmrs_ram, tmrs_lane, tmrs_merge
`timescale 1ns / 1ps

module thread_masked_register_scoreboard
  import tmrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           kind,
  input  logic [WARP_W-1:0]    warp,
  input  logic [WARP_SIZE-1:0] thread_mask,
  input  logic                 long_load,
  input  logic [REG_W-1:0]     reg_a,
  input  logic [REG_W-1:0]     reg_b,
  input  logic [REG_W-1:0]     reg_c,
  input  logic [REG_W-1:0]     reg_d,
  input  logic [REG_W-1:0]     reg_e,
  input  logic [REG_W-1:0]     reg_f,
  input  logic                 last,
  output logic                 valid,
  output logic                 collision,
  output logic                 check_done,
  output logic                 pending_writes,
  output logic                 slot_a_long_op,
  output logic                 double_reserve
);

  state_t st, st_next;

  logic [ADDR_W-1:0] clr_addr;
  logic [SLOT_W-1:0] wcnt;
  logic              accum;
  logic              accum_next;
  logic [CNT_W-1:0]  busy_count [WARPS];

  kind_t                kind_q;
  logic [WARP_W-1:0]    warp_q;
  logic [WARP_SIZE-1:0] mask_q;
  logic                 long_q;
  logic                 last_q;
  logic                 wok_q;
  logic [REG_W-1:0]     regs_q   [SLOTS];
  logic                 active_q [SLOTS];
  lane_res_t            res_q    [SLOTS];

  logic [REG_W-1:0]   regs_in [SLOTS];
  logic               wok_in;
  logic               accept;
  logic               first   [SLOTS];
  logic [ENTRY_W-1:0] rdata   [SLOTS];
  lane_res_t          res     [SLOTS];
  merge_res_t         merged;
  logic               coll;
  logic               done;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;

  assign regs_in[0] = reg_a;
  assign regs_in[1] = reg_b;
  assign regs_in[2] = reg_c;
  assign regs_in[3] = reg_d;
  assign regs_in[4] = reg_e;
  assign regs_in[5] = reg_f;

  assign wok_in = (int'(warp) < WARPS);
  assign accept = start && !busy;

  // a slot is first unless an earlier active slot names the same register
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      first[i] = 1'b1;
      for (int j = 0; j < i; j++) begin
        if (active_q[j] && (regs_q[j] == regs_q[i])) begin
          first[i] = 1'b0;
        end
      end
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_lane
    tmrs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr ({warp, regs_in[g]}),
      .rdata (rdata[g])
    );

    tmrs_lane u_lane (
      .kind      (kind_q),
      .mask      (mask_q),
      .long_load (long_q),
      .active    (active_q[g]),
      .first     (first[g]),
      .rdata     (rdata[g]),
      .res       (res[g])
    );
  end

  tmrs_merge u_merge (
    .res       (res),
    .count_old (busy_count[warp_q]),
    .merged    (merged)
  );

  always_comb begin
    if (kind_q == KIND_CHECK) begin
      coll       = accum | merged.hit;
      done       = last_q;
      accum_next = last_q ? 1'b0 : coll;
    end else begin
      coll       = accum;
      done       = 1'b0;
      accum_next = accum;
    end
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_CLEAR: begin
        if (&clr_addr) begin
          st_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          st_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        st_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (wcnt == SLOT_W'(SLOTS - 1)) begin
          st_next = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_CLEAR;
      end
    endcase
  end

  // outputs and ram write port
  always_comb begin
    busy      = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    unique case (st)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_EVAL: begin
      end
      ST_WRITE: begin
        ram_we    = ((kind_q == KIND_RESERVE) || (kind_q == KIND_RELEASE)) && active_q[wcnt];
        ram_waddr = {warp_q, regs_q[wcnt]};
        ram_wdata = {res_q[wcnt].long_new, res_q[wcnt].busy_new};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_CLEAR;
      clr_addr <= '0;
      wcnt     <= '0;
      valid    <= 1'b0;
      accum    <= 1'b0;
      for (int i = 0; i < WARPS; i++) begin
        busy_count[i] <= '0;
      end
    end else begin
      st    <= st_next;
      valid <= 1'b0;
      unique case (st)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        ST_IDLE: begin
          wcnt <= '0;
        end
        ST_EVAL: begin
          accum <= accum_next;
          if (wok_q) begin
            busy_count[warp_q] <= merged.count_new;
          end
        end
        ST_WRITE: begin
          wcnt <= wcnt + 1'b1;
          if (wcnt == SLOT_W'(SLOTS - 1)) begin
            valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // item capture and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind_t'(kind);
      warp_q <= warp;
      mask_q <= thread_mask;
      long_q <= long_load;
      last_q <= last;
      wok_q  <= wok_in;
      for (int i = 0; i < SLOTS; i++) begin
        regs_q[i]   <= regs_in[i];
        active_q[i] <= wok_in && (regs_in[i] != '0) && (int'(regs_in[i]) < REGS);
      end
    end
    if (st == ST_EVAL) begin
      res_q          <= res;
      collision      <= coll;
      check_done     <= done;
      pending_writes <= wok_q && (merged.count_new != '0);
      slot_a_long_op <= active_q[0] && (res[0].long_new != '0);
      double_reserve <= merged.dbl;
    end
  end

endmodule
